// File: rtl/dspt_pkg.sv
// ============================================================================
// dspt_pkg: shared definitions for the deadline-sorted pending table
// Field widths, action and status codes, cell data types, and the
// remaining-time helper used by the cells and the top level.
// ============================================================================
package dspt_pkg;

    // Table depth default and fixed field widths
    localparam int DEF_DEPTH  = 16;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 4;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 2;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 4 * DATA_W;
    localparam int OUT_BITS   = POS_W + 3 * DATA_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

    // One table entry as handed between neighboring cells
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] created;
        logic [DATA_W-1:0] timeout;
    } t_entry;

    // Command broadcast to every cell
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] created;
        logic [DATA_W-1:0] timeout;
        logic [DATA_W-1:0] now;
        logic [DATA_W-1:0] new_rem;
    } t_cmd;

    // Remaining time: timeout minus wrapped elapsed time, floored at zero
    function automatic logic [DATA_W-1:0] time_left(
        input logic [DATA_W-1:0] created,
        input logic [DATA_W-1:0] timeout,
        input logic [DATA_W-1:0] now
    );
        logic [DATA_W-1:0] elapsed;
        elapsed = now - created;
        return (elapsed >= timeout) ? '0 : (timeout - elapsed);
    endfunction

endpackage

// File: rtl/dspt_cell.sv
// ============================================================================
// dspt_cell: one slot of the sorted pending table
// Holds one entry, evaluates its remaining time and id match, takes part in
// the first-hit prefix chain and shifts data to or from its neighbors.
// ============================================================================
module dspt_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dspt_pkg::t_cmd               i_cmd,
    input  logic                         i_eval_en,
    input  logic                         i_write_en,
    input  logic                         i_any,
    input  logic                         i_at_end,
    input  logic                         i_prefix,
    input  dspt_pkg::t_entry             i_left,
    input  dspt_pkg::t_entry             i_right,
    output logic                         o_prefix,
    output logic                         o_hit,
    output dspt_pkg::t_entry             o_entry,
    output logic [dspt_pkg::DATA_W-1:0]  o_rem
);

    logic                        r_valid;
    logic [dspt_pkg::DATA_W-1:0] r_id;
    logic [dspt_pkg::DATA_W-1:0] r_created;
    logic [dspt_pkg::DATA_W-1:0] r_timeout;
    logic [dspt_pkg::DATA_W-1:0] r_rem;
    logic                        r_match;

    dspt_pkg::t_entry n_entry;
    logic             flag;
    logic             load;

    assign o_entry = '{valid: r_valid, id: r_id, created: r_created, timeout: r_timeout};
    assign o_rem   = r_rem;

    // Insert looks for the first strictly larger remaining time, else id match
    assign flag = (i_cmd.action == dspt_pkg::ACT_INSERT)
                ? (r_valid && (i_cmd.new_rem < r_rem))
                : r_match;
    assign o_prefix = i_prefix | flag;
    assign o_hit    = flag & ~i_prefix;

    // New entry lands at the first hit, or at the end when nothing hits
    assign load = o_hit | (~i_any & i_at_end);

    // Next entry contents
    always_comb begin
        n_entry = o_entry;
        if (i_write_en) begin
            case (i_cmd.action)
                dspt_pkg::ACT_INSERT: begin
                    if (load) begin
                        n_entry = '{valid: 1'b1, id: i_cmd.id,
                                    created: i_cmd.created, timeout: i_cmd.timeout};
                    end else if (i_prefix) begin
                        n_entry = i_left;
                    end
                end
                dspt_pkg::ACT_REMOVE: begin
                    if (o_prefix) begin
                        n_entry = i_right;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    // Payload and per-slot evaluation
    always_ff @(posedge i_clk) begin
        r_id      <= n_entry.id;
        r_created <= n_entry.created;
        r_timeout <= n_entry.timeout;
        if (i_eval_en) begin
            r_rem   <= dspt_pkg::time_left(r_created, r_timeout, i_cmd.now);
            r_match <= r_valid && (r_id == i_cmd.id);
        end
    end

endmodule

// File: rtl/deadline_sorted_pending_table.sv
// ============================================================================
// deadline_sorted_pending_table: pending message table sorted by deadline
// Top level: command sequencer, cell chain and result register.
// ============================================================================
// Usage:
//   Slave channel (i_s_*) takes one command per transaction: tuser carries
//   the action (insert, lookup, remove), tdata the id, creation time,
//   timeout and current time. Master channel (o_m_*) returns exactly one
//   result per command: tuser carries the status, tdata the position,
//   found creation time, found timeout and remaining time.
//   Each command runs through the steps accept, per-slot evaluation
//   (every cell computes its remaining time and id match in parallel), and
//   apply (first-hit prefix chain across the cells, shift, result load).
//   The apply step loads the result register, which drives o_m_tvalid; a
//   new command is taken only after the previous command has been applied.
//   The result register decouples the two sides: a new command is accepted
//   while a result still waits, and the apply step waits only while the
//   previous result has not yet been taken.
//   Reset (synchronous, active low) empties the table: all slots invalid,
//   count zero, no result pending. No clearing pass is needed.
// ============================================================================
module deadline_sorted_pending_table #(
    parameter int TABLE_DEPTH = dspt_pkg::DEF_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command: tdata = msg_id, created_at, timeout_ticks, now (low bit up)
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [dspt_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser = action
    input  logic [dspt_pkg::ACT_W-1:0]        i_s_tuser,
    // Result: tdata = position, found_created, found_timeout, remaining, pad
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [dspt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // tuser = status
    output logic [dspt_pkg::STAT_W-1:0]       o_m_tuser
);

    localparam int DW    = dspt_pkg::DATA_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    dspt_pkg::t_state r_state, n_state;
    dspt_pkg::t_cmd   r_cmd;
    logic [CNT_W-1:0] r_count;

    logic                          r_out_valid;
    logic [dspt_pkg::STAT_W-1:0]   r_out_status;
    logic [dspt_pkg::POS_W-1:0]    r_out_pos;
    logic [DW-1:0]                 r_out_fc;
    logic [DW-1:0]                 r_out_ft;
    logic [DW-1:0]                 r_out_rem;

    logic s_accept;
    logic eval_en;
    logic apply_go;
    logic write_en;
    logic full;
    logic any;

    dspt_pkg::t_entry w_entry [TABLE_DEPTH];
    logic [DW-1:0]    w_rem   [TABLE_DEPTH];
    logic [TABLE_DEPTH:0]   w_prefix;
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_at_end;

    logic [dspt_pkg::STAT_W-1:0] res_status;
    logic [dspt_pkg::POS_W-1:0]  res_pos;
    logic [DW-1:0]               res_fc;
    logic [DW-1:0]               res_ft;
    logic [DW-1:0]               res_rem;
    logic [IDX_W-1:0]            hit_idx;
    logic [DW-1:0]               hit_fc;
    logic [DW-1:0]               hit_ft;
    logic [DW-1:0]               hit_rem;

    assign s_accept = i_s_tvalid & o_s_tready;
    assign full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign any      = w_prefix[TABLE_DEPTH];
    assign w_prefix[0] = 1'b0;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dspt_pkg::S_IDLE:  if (s_accept) n_state = dspt_pkg::S_EVAL;
            dspt_pkg::S_EVAL:  n_state = dspt_pkg::S_APPLY;
            dspt_pkg::S_APPLY: if (apply_go) n_state = dspt_pkg::S_IDLE;
            default:           n_state = dspt_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        eval_en    = 1'b0;
        apply_go   = 1'b0;
        case (r_state)
            dspt_pkg::S_IDLE:  o_s_tready = 1'b1;
            dspt_pkg::S_EVAL:  eval_en    = 1'b1;
            dspt_pkg::S_APPLY: apply_go   = ~r_out_valid | i_m_tready;
            default: begin
            end
        endcase
    end

    // Only inserts into a non-full table and successful removes change state
    assign write_en = apply_go &&
                      (((r_cmd.action == dspt_pkg::ACT_INSERT) && !full) ||
                       ((r_cmd.action == dspt_pkg::ACT_REMOVE) && any));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dspt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command capture; the new entry's remaining time is formed during eval
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd.action  <= i_s_tuser;
            r_cmd.id      <= i_s_tdata[DW-1:0];
            r_cmd.created <= i_s_tdata[2*DW-1:DW];
            r_cmd.timeout <= i_s_tdata[3*DW-1:2*DW];
            r_cmd.now     <= i_s_tdata[4*DW-1:3*DW];
        end
        if (eval_en) begin
            r_cmd.new_rem <= dspt_pkg::time_left(r_cmd.created, r_cmd.timeout, r_cmd.now);
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (write_en) begin
            if (r_cmd.action == dspt_pkg::ACT_INSERT) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Cell chain
    for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
        dspt_pkg::t_entry left_e;
        dspt_pkg::t_entry right_e;

        assign w_at_end[c] = (r_count == CNT_W'(c));

        if (c == 0) begin : g_first
            assign left_e = '0;
        end else begin : g_mid_l
            assign left_e = w_entry[c-1];
        end
        if (c == TABLE_DEPTH - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_mid_r
            assign right_e = w_entry[c+1];
        end

        dspt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (r_cmd),
            .i_eval_en  (eval_en),
            .i_write_en (write_en),
            .i_any      (any),
            .i_at_end   (w_at_end[c]),
            .i_prefix   (w_prefix[c]),
            .i_left     (left_e),
            .i_right    (right_e),
            .o_prefix   (w_prefix[c+1]),
            .o_hit      (w_hit[c]),
            .o_entry    (w_entry[c]),
            .o_rem      (w_rem[c])
        );
    end

    // Hit index and selected entry data (at most one hit)
    always_comb begin
        hit_idx = '0;
        hit_fc  = '0;
        hit_ft  = '0;
        hit_rem = '0;
        for (int c = 0; c < TABLE_DEPTH; c++) begin
            if (w_hit[c]) begin
                hit_idx = hit_idx | IDX_W'(c);
                hit_fc  = hit_fc  | w_entry[c].created;
                hit_ft  = hit_ft  | w_entry[c].timeout;
                hit_rem = hit_rem | w_rem[c];
            end
        end
    end

    // Result formation
    always_comb begin
        res_status = dspt_pkg::STAT_NOT_FOUND;
        res_pos    = '0;
        res_fc     = '0;
        res_ft     = '0;
        res_rem    = '0;
        case (r_cmd.action)
            dspt_pkg::ACT_INSERT: begin
                if (full) begin
                    res_status = dspt_pkg::STAT_FULL;
                end else begin
                    res_status = dspt_pkg::STAT_OK;
                    res_pos    = any ? dspt_pkg::POS_W'(hit_idx)
                                     : dspt_pkg::POS_W'(r_count);
                    res_rem    = r_cmd.new_rem;
                end
            end
            dspt_pkg::ACT_LOOKUP: begin
                if (any) begin
                    res_status = dspt_pkg::STAT_OK;
                    res_pos    = dspt_pkg::POS_W'(hit_idx);
                    res_fc     = hit_fc;
                    res_ft     = hit_ft;
                    res_rem    = hit_rem;
                end
            end
            dspt_pkg::ACT_REMOVE: begin
                if (any) begin
                    res_status = dspt_pkg::STAT_OK;
                    res_pos    = dspt_pkg::POS_W'(hit_idx);
                end
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_out_status <= res_status;
            r_out_pos    <= res_pos;
            r_out_fc     <= res_fc;
            r_out_ft     <= res_ft;
            r_out_rem    <= res_rem;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{dspt_pkg::OUT_PAD_W{1'b0}}, r_out_rem, r_out_ft,
                         r_out_fc, r_out_pos};

endmodule

// File: rtl/dspt_checker.sv
// ============================================================================
// dspt_checker: port-level checks for the pending table
// Watches the top-level stream ports; attached by bind.
// ============================================================================
module dspt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [dspt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input logic [dspt_pkg::STAT_W-1:0]       o_m_tuser
);

    logic s_acc;
    assign s_acc = i_s_tvalid & o_s_tready;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // Command side closes while a transaction is in work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("second command accepted during processing");

    // Failed commands carry an all-zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != dspt_pkg::STAT_OK) |-> (o_m_tdata == '0))
        else $error("non-zero payload on failed command");

    // A fresh result follows its command by the fixed pipeline delay
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_acc, 3))
        else $error("result without matching command");

endmodule

bind deadline_sorted_pending_table dspt_checker u_dspt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
